>>> design/triangle_tangent_binormal_top_assert.svh
// Assertion macros shared by the triangle tangent/binormal checker
`ifndef TRIANGLE_TANGENT_BINORMAL_TOP_ASSERT_SVH
`define TRIANGLE_TANGENT_BINORMAL_TOP_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define TBN_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication checked outside reset
`define TBN_ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

>>> design/tbn_pkg.sv
// Package: word types and widths of the triangle tangent/binormal block
package tbn_pkg;

  localparam int unsigned InW   = 32;  // input coordinate width
  localparam int unsigned DltW  = 33;  // edge and texture delta width
  localparam int unsigned AccW  = 67;  // exact a*b - c*d width
  localparam int unsigned OutW  = 16;  // Q2.14 result width
  localparam int unsigned NumW  = 45;  // dividend width of the final division

  typedef struct packed {
    logic signed [InW-1:0] pos_x;
    logic signed [InW-1:0] pos_y;
    logic signed [InW-1:0] pos_z;
    logic signed [InW-1:0] tex_u;
    logic signed [InW-1:0] tex_v;
  } vtx_t;

  typedef struct packed {
    logic signed [OutW-1:0] tangent_x;
    logic signed [OutW-1:0] tangent_y;
    logic signed [OutW-1:0] tangent_z;
    logic signed [OutW-1:0] binormal_x;
    logic signed [OutW-1:0] binormal_y;
    logic signed [OutW-1:0] binormal_z;
    logic                   degenerate;
  } tbn_t;

endpackage

>>> design/tbn_in_if.sv
// Interface: vertex input channel
interface tbn_in_if;
  logic          valid;
  logic          ready;
  tbn_pkg::vtx_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/tbn_out_if.sv
// Interface: tangent/binormal result channel
interface tbn_out_if;
  logic          valid;
  logic          ready;
  tbn_pkg::tbn_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/triangle_tangent_binormal_top.sv
// Top level: triangle tangent/binormal unit with a shared bit-serial datapath
// Corners 0 and 1 of a triangle are taken and held and give no word.
// Corner 2 starts the bit-serial multiplies (14 products of 33 bits), then per vector
// block scaling one bit a cycle, three 30-bit squares, a 32-step square root and
// three 45-step divisions.
// Input is not taken while a triangle is in work; a finished word waits in the output register.
// Reset (async, active low) clears the corner count, the sequencer and the output valid.
module triangle_tangent_binormal_top (
  input  logic    clk_i,
  input  logic    rst_ni,
  tbn_in_if.sink  in_i,
  tbn_out_if.source out_o
);

  localparam int unsigned AccW = tbn_pkg::AccW;
  localparam int unsigned DltW = tbn_pkg::DltW;
  localparam int unsigned InW  = tbn_pkg::InW;
  localparam int unsigned OutW = tbn_pkg::OutW;
  localparam int unsigned NumW = tbn_pkg::NumW;

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MLD  = 4'd1;   // load product operands
  localparam logic [3:0] S_MUL  = 4'd2;   // shift-add one multiplier bit
  localparam logic [3:0] S_LOAD = 4'd3;   // take magnitudes of one vector
  localparam logic [3:0] S_NORM = 4'd4;   // block scale one bit a cycle
  localparam logic [3:0] S_SLD  = 4'd5;   // load a square
  localparam logic [3:0] S_SQR  = 4'd6;   // shift-add one bit of a square
  localparam logic [3:0] S_SQRT = 4'd7;   // one root digit
  localparam logic [3:0] S_DLD  = 4'd8;   // load a division
  localparam logic [3:0] S_DIV  = 4'd9;   // one quotient bit
  localparam logic [3:0] S_DONE = 4'd10;  // hand word to output register

  logic [3:0]  state_q;
  logic [1:0]  cc_q;
  logic [2:0]  job_q;
  logic        phase_q;
  logic [5:0]  bit_q;
  logic        vec_q;
  logic [1:0]  cnt_q;
  logic        degen_q;
  logic        out_valid_q;
  tbn_pkg::tbn_t out_data_q;

  logic [InW-1:0]  held_q [10];
  logic [DltW-1:0] e1_q [3];
  logic [DltW-1:0] e2_q [3];
  logic [DltW-1:0] du1_q, dv1_q, du2_q, dv2_q;
  logic [AccW-1:0] acc_q, mcand_q;
  logic [DltW-1:0] mplier_q;
  logic [AccW-1:0] det_q;
  logic [AccW-1:0] tv_q [3];
  logic [AccW-1:0] bv_q [3];
  logic            neg_q [3];
  logic [AccW-1:0] m_q [3];
  logic [63:0]     x_q, r_q, sb_q;
  logic [31:0]     len_q;
  logic [NumW-1:0] num_q;
  logic [32:0]     rem_q;
  logic [OutW-1:0] quo_q;
  logic [OutW-1:0] res_q [6];

  logic in_fire;
  logic [InW-1:0] in_v [5];

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid & in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  assign in_v[0] = in_i.data.pos_x;
  assign in_v[1] = in_i.data.pos_y;
  assign in_v[2] = in_i.data.pos_z;
  assign in_v[3] = in_i.data.tex_u;
  assign in_v[4] = in_i.data.tex_v;

  // operand select: det, then tangent x/y/z, then binormal x/y/z
  logic [1:0]      sel_i;
  logic [DltW-1:0] op_a, op_b;
  always_comb begin
    sel_i = 2'd0;
    op_a  = '0;
    op_b  = '0;
    unique case (job_q) inside
      3'd1, 3'd4: sel_i = 2'd0;
      3'd2, 3'd5: sel_i = 2'd1;
      3'd3, 3'd6: sel_i = 2'd2;
      default:    sel_i = 2'd0;
    endcase
    if (job_q == 3'd0) begin
      op_a = phase_q ? du2_q : du1_q;
      op_b = phase_q ? dv1_q : dv2_q;
    end else if (job_q < 3'd4) begin
      op_a = phase_q ? e2_q[sel_i] : e1_q[sel_i];
      op_b = phase_q ? dv1_q : dv2_q;
    end else begin
      op_a = phase_q ? e1_q[sel_i] : e2_q[sel_i];
      op_b = phase_q ? du2_q : du1_q;
    end
  end

  // shared shift-add step; the sign bit of a signed multiplier weighs negative
  logic            step_sub;
  logic [AccW-1:0] acc_step;
  assign step_sub = (state_q == S_MUL) & ((bit_q == 6'd32) ^ phase_q);
  assign acc_step = !mplier_q[0] ? acc_q :
                    (step_sub ? acc_q - mcand_q : acc_q + mcand_q);

  // vector source, magnitudes and block scale flags
  logic [AccW-1:0] src [3];
  logic [AccW-1:0] or_all;
  logic            too_big, too_small;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      src[i] = vec_q ? bv_q[i] : tv_q[i];
    end
  end
  assign or_all    = m_q[0] | m_q[1] | m_q[2];
  assign too_big   = |or_all[AccW-1:30];
  assign too_small = !or_all[29];

  // root digit
  logic [63:0] sq_t, r_nxt;
  logic        sq_ge;
  assign sq_t  = r_q + sb_q;
  assign sq_ge = (x_q >= sq_t);
  assign r_nxt = sq_ge ? (r_q >> 1) + sb_q : (r_q >> 1);

  // quotient bit
  logic [32:0]     rem_t;
  logic            dv_ge;
  logic [OutW-1:0] q_fin;
  logic [2:0]      res_idx;
  assign rem_t   = {rem_q[31:0], num_q[NumW-1]};
  assign dv_ge   = (rem_t >= {1'b0, len_q});
  assign q_fin   = {quo_q[OutW-2:0], dv_ge};
  assign res_idx = (vec_q ? 3'd3 : 3'd0) + {1'b0, cnt_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cc_q        <= 2'd0;
      job_q       <= 3'd0;
      phase_q     <= 1'b0;
      bit_q       <= 6'd0;
      vec_q       <= 1'b0;
      cnt_q       <= 2'd0;
      degen_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // drop a taken word unless the sequencer refills the register now
      if (out_valid_q && out_o.ready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (cc_q == 2'd2) begin
              cc_q    <= 2'd0;
              job_q   <= 3'd0;
              phase_q <= 1'b0;
              state_q <= S_MLD;
            end else begin
              cc_q <= cc_q + 2'd1;
            end
          end
        end
        S_MLD: begin
          bit_q   <= 6'd0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          bit_q <= bit_q + 6'd1;
          if (bit_q == 6'd32) begin
            if (!phase_q) begin
              phase_q <= 1'b1;
              state_q <= S_MLD;
            end else begin
              phase_q <= 1'b0;
              if (job_q == 3'd6) begin
                vec_q   <= 1'b0;
                state_q <= S_LOAD;
              end else begin
                job_q   <= job_q + 3'd1;
                state_q <= S_MLD;
              end
            end
          end
        end
        S_LOAD: begin
          if (!vec_q && det_q == '0) begin
            degen_q <= 1'b1;
            state_q <= S_DONE;
          end else begin
            state_q <= S_NORM;
          end
        end
        S_NORM: begin
          if (or_all == '0) begin
            degen_q <= 1'b1;
            state_q <= S_DONE;
          end else if (!too_big && !too_small) begin
            cnt_q   <= 2'd0;
            state_q <= S_SLD;
          end
        end
        S_SLD: begin
          bit_q   <= 6'd0;
          state_q <= S_SQR;
        end
        S_SQR: begin
          bit_q <= bit_q + 6'd1;
          if (bit_q == 6'd29) begin
            if (cnt_q == 2'd2) begin
              cnt_q   <= 2'd0;
              state_q <= S_SQRT;
            end else begin
              cnt_q   <= cnt_q + 2'd1;
              state_q <= S_SLD;
            end
          end
        end
        S_SQRT: begin
          if (sb_q[0]) begin
            cnt_q   <= 2'd0;
            state_q <= S_DLD;
          end
        end
        S_DLD: begin
          bit_q   <= 6'd0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          bit_q <= bit_q + 6'd1;
          if (bit_q == 6'(NumW - 1)) begin
            if (cnt_q == 2'd2) begin
              cnt_q <= 2'd0;
              if (!vec_q) begin
                vec_q   <= 1'b1;
                state_q <= S_LOAD;
              end else begin
                degen_q <= 1'b0;
                state_q <= S_DONE;
              end
            end else begin
              cnt_q   <= cnt_q + 2'd1;
              state_q <= S_DLD;
            end
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (cc_q == 2'd0) begin
            for (int i = 0; i < 5; i++) held_q[i] <= in_v[i];
          end else if (cc_q == 2'd1) begin
            for (int i = 0; i < 5; i++) held_q[5+i] <= in_v[i];
          end else begin
            for (int i = 0; i < 3; i++) begin
              e1_q[i] <= {held_q[5+i][InW-1], held_q[5+i]} - {held_q[i][InW-1], held_q[i]};
              e2_q[i] <= {in_v[i][InW-1], in_v[i]} - {held_q[i][InW-1], held_q[i]};
            end
            du1_q <= {held_q[8][InW-1], held_q[8]} - {held_q[3][InW-1], held_q[3]};
            dv1_q <= {held_q[9][InW-1], held_q[9]} - {held_q[4][InW-1], held_q[4]};
            du2_q <= {in_v[3][InW-1], in_v[3]} - {held_q[3][InW-1], held_q[3]};
            dv2_q <= {in_v[4][InW-1], in_v[4]} - {held_q[4][InW-1], held_q[4]};
            acc_q <= '0;
          end
        end
      end
      S_MLD: begin
        mcand_q  <= {{(AccW-DltW){op_a[DltW-1]}}, op_a};
        mplier_q <= op_b;
      end
      S_MUL: begin
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
        if (bit_q == 6'd32 && phase_q) begin
          acc_q <= '0;
          unique case (job_q)
            3'd0: det_q <= acc_step;
            3'd1: tv_q[0] <= acc_step;
            3'd2: tv_q[1] <= acc_step;
            3'd3: tv_q[2] <= acc_step;
            3'd4: bv_q[0] <= acc_step;
            3'd5: bv_q[1] <= acc_step;
            3'd6: bv_q[2] <= acc_step;
            default: det_q <= acc_step;
          endcase
        end else begin
          acc_q <= acc_step;
        end
      end
      S_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          neg_q[i] <= src[i][AccW-1];
          m_q[i]   <= src[i][AccW-1] ? '0 - src[i] : src[i];
        end
      end
      S_NORM: begin
        acc_q <= '0;
        if (too_big) begin
          for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
        end else if (too_small && or_all != '0) begin
          for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
        end
      end
      S_SLD: begin
        mcand_q  <= m_q[cnt_q];
        mplier_q <= m_q[cnt_q][DltW-1:0];
      end
      S_SQR: begin
        acc_q    <= acc_step;
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
        if (bit_q == 6'd29 && cnt_q == 2'd2) begin
          x_q  <= acc_step[63:0];
          r_q  <= '0;
          sb_q <= 64'h4000_0000_0000_0000;
        end
      end
      S_SQRT: begin
        x_q  <= sq_ge ? x_q - sq_t : x_q;
        r_q  <= r_nxt;
        sb_q <= sb_q >> 2;
        if (sb_q[0]) len_q <= r_nxt[31:0];
      end
      S_DLD: begin
        // dividend is |c| * 16384 plus half the length
        num_q <= {1'b0, m_q[cnt_q][29:0], 14'd0} + {14'd0, len_q[31:1]};
        rem_q <= '0;
        quo_q <= '0;
      end
      S_DIV: begin
        rem_q <= dv_ge ? rem_t - {1'b0, len_q} : rem_t;
        quo_q <= q_fin;
        num_q <= num_q << 1;
        if (bit_q == 6'(NumW - 1)) begin
          res_q[res_idx] <= (neg_q[cnt_q] ^ det_q[AccW-1]) ? '0 - q_fin : q_fin;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_data_q.tangent_x  <= degen_q ? '0 : res_q[0];
          out_data_q.tangent_y  <= degen_q ? '0 : res_q[1];
          out_data_q.tangent_z  <= degen_q ? '0 : res_q[2];
          out_data_q.binormal_x <= degen_q ? '0 : res_q[3];
          out_data_q.binormal_y <= degen_q ? '0 : res_q[4];
          out_data_q.binormal_z <= degen_q ? '0 : res_q[5];
          out_data_q.degenerate <= degen_q;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> design/tbn_checker.sv
// Checker: port-level assertions for the triangle tangent/binormal top, with bind
`include "triangle_tangent_binormal_top_assert.svh"
module tbn_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [15:0] tx_i,
  input logic signed [15:0] ty_i,
  input logic signed [15:0] tz_i,
  input logic signed [15:0] bx_i,
  input logic signed [15:0] by_i,
  input logic signed [15:0] bz_i,
  input logic               degen_i
);

  `TBN_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(tx_i) && $stable(bz_i) && $stable(degen_i), "stalled word changed")
  `TBN_ASSERT_IMP(a_degen_zero, clk_i, rst_ni, out_valid_i && degen_i, tx_i == 0 && ty_i == 0 && tz_i == 0 && bx_i == 0 && by_i == 0 && bz_i == 0, "degenerate word carries nonzero vector")
  `TBN_ASSERT_IMP(a_tan_range, clk_i, rst_ni, out_valid_i, tx_i >= -16384 && tx_i <= 16384 && ty_i >= -16384 && ty_i <= 16384 && tz_i >= -16384 && tz_i <= 16384, "tangent out of unit range")
  `TBN_ASSERT_IMP(a_bin_range, clk_i, rst_ni, out_valid_i, bx_i >= -16384 && bx_i <= 16384 && by_i >= -16384 && by_i <= 16384 && bz_i >= -16384 && bz_i <= 16384, "binormal out of unit range")

endmodule

bind triangle_tangent_binormal_top tbn_checker u_tbn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .tx_i        (out_o.data.tangent_x),
  .ty_i        (out_o.data.tangent_y),
  .tz_i        (out_o.data.tangent_z),
  .bx_i        (out_o.data.binormal_x),
  .by_i        (out_o.data.binormal_y),
  .bz_i        (out_o.data.binormal_z),
  .degen_i     (out_o.data.degenerate)
);

>>> dv/tb_top.sv
// Testbench for the triangle tangent/binormal unit: random vertex stream against a predictor
`timescale 1ns / 100ps

module tb_top;

  typedef logic signed [127:0] wide_t;

  localparam int unsigned IdleLimit = 20000;

  logic clk_i;
  logic rst_ni;

  tbn_in_if  in_if ();
  tbn_out_if out_if ();

  triangle_tangent_binormal_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // 12 ns period
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Predictor state: corner count and the two held corners
  int            corners_held;
  tbn_pkg::vtx_t corner0;
  tbn_pkg::vtx_t corner1;

  tbn_pkg::tbn_t expected_words[$];
  int   error_count;
  int   idle_cycles = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r;
    longint unsigned bitv;
    r = 0;
    bitv = 64'h1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // Normalize one exact vector to Q2.14; return 0 for the zero vector
  function automatic bit unit_q14(input wide_t c0, input wide_t c1, input wide_t c2,
                                  input bit flip, output logic signed [15:0] q0,
                                  output logic signed [15:0] q1,
                                  output logic signed [15:0] q2);
    wide_t c[3];
    wide_t m[3];
    bit neg[3];
    longint unsigned s[3];
    longint unsigned sum;
    longint unsigned len;
    longint unsigned v;
    logic signed [15:0] q[3];
    int n;
    int b;
    c[0] = c0;
    c[1] = c1;
    c[2] = c2;
    n = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = c[i][127];
      m[i] = neg[i] ? -c[i] : c[i];
      b = 0;
      for (int k = 0; k < 128; k++) if (m[i][k]) b = k + 1;
      if (b > n) n = b;
    end
    q0 = '0;
    q1 = '0;
    q2 = '0;
    if (n == 0) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (n > 30) s[i] = 64'(m[i] >> (n - 30));
      else s[i] = 64'(m[i] << (30 - n));
      sum += s[i] * s[i];
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      v = (s[i] * 16384 + (len >> 1)) / len;
      q[i] = (neg[i] != flip) ? -16'(v) : 16'(v);
    end
    q0 = q[0];
    q1 = q[1];
    q2 = q[2];
    return 1'b1;
  endfunction

  // Advance the predictor by one accepted vertex; queue a word on the third corner
  task automatic predict_corner(input tbn_pkg::vtx_t vtx);
    wide_t e1[3];
    wide_t e2[3];
    wide_t du1, dv1, du2, dv2, det;
    wide_t tv[3];
    wide_t bv[3];
    wide_t p0[3];
    wide_t p1[3];
    wide_t p2[3];
    tbn_pkg::tbn_t word;
    bit ok;
    bit flip;
    if (corners_held == 0) begin
      corner0 = vtx;
      corners_held = 1;
    end else if (corners_held == 1) begin
      corner1 = vtx;
      corners_held = 2;
    end else begin
      corners_held = 0;
      p0[0] = corner0.pos_x; p0[1] = corner0.pos_y; p0[2] = corner0.pos_z;
      p1[0] = corner1.pos_x; p1[1] = corner1.pos_y; p1[2] = corner1.pos_z;
      p2[0] = vtx.pos_x;     p2[1] = vtx.pos_y;     p2[2] = vtx.pos_z;
      for (int i = 0; i < 3; i++) begin
        e1[i] = p1[i] - p0[i];
        e2[i] = p2[i] - p0[i];
      end
      du1 = wide_t'(corner1.tex_u) - wide_t'(corner0.tex_u);
      dv1 = wide_t'(corner1.tex_v) - wide_t'(corner0.tex_v);
      du2 = wide_t'(vtx.tex_u) - wide_t'(corner0.tex_u);
      dv2 = wide_t'(vtx.tex_v) - wide_t'(corner0.tex_v);
      det = du1 * dv2 - du2 * dv1;
      for (int i = 0; i < 3; i++) begin
        tv[i] = dv2 * e1[i] - dv1 * e2[i];
        bv[i] = du1 * e2[i] - du2 * e1[i];
      end
      flip = det[127];
      ok = (det != 0);
      word = '0;
      if (ok) ok = unit_q14(tv[0], tv[1], tv[2], flip,
                            word.tangent_x, word.tangent_y, word.tangent_z);
      if (ok) ok = unit_q14(bv[0], bv[1], bv[2], flip,
                            word.binormal_x, word.binormal_y, word.binormal_z);
      if (!ok) word = '0;
      word.degenerate = !ok;
      expected_words = {expected_words, word};
    end
  endtask

  // Send one vertex word after a random gap; hold valid across back-to-back words
  task automatic send_vertex(input tbn_pkg::vtx_t vtx);
    int gap;
    gap = $urandom_range(0, 15);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= vtx;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_corner(vtx);
  endtask

  task automatic send_triangle(input tbn_pkg::vtx_t a, input tbn_pkg::vtx_t b,
                               input tbn_pkg::vtx_t c);
    send_vertex(a);
    send_vertex(b);
    send_vertex(c);
  endtask

  function automatic tbn_pkg::vtx_t mk(input int x, input int y, input int z, input int u,
                                       input int v);
    tbn_pkg::vtx_t r;
    r.pos_x = x;
    r.pos_y = y;
    r.pos_z = z;
    r.tex_u = u;
    r.tex_v = v;
    return r;
  endfunction

  // Full-range or small-magnitude random coordinate
  function automatic logic [31:0] rand_coord(input bit narrow);
    if (narrow) return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
    return $urandom;
  endfunction

  function automatic tbn_pkg::vtx_t rand_vertex(input bit narrow);
    return mk(rand_coord(narrow), rand_coord(narrow), rand_coord(narrow),
              rand_coord(narrow), rand_coord(narrow));
  endfunction

  // Receive side: random stall before each word, check against the oldest expectation
  initial begin
    int stall;
    tbn_pkg::tbn_t want;
    tbn_pkg::tbn_t got;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 15);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      got = out_if.data;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = expected_words.pop_front();
        if (got.tangent_x != want.tangent_x)
          report_mismatch("tangent_x", got.tangent_x, want.tangent_x);
        if (got.tangent_y != want.tangent_y)
          report_mismatch("tangent_y", got.tangent_y, want.tangent_y);
        if (got.tangent_z != want.tangent_z)
          report_mismatch("tangent_z", got.tangent_z, want.tangent_z);
        if (got.binormal_x != want.binormal_x)
          report_mismatch("binormal_x", got.binormal_x, want.binormal_x);
        if (got.binormal_y != want.binormal_y)
          report_mismatch("binormal_y", got.binormal_y, want.binormal_y);
        if (got.binormal_z != want.binormal_z)
          report_mismatch("binormal_z", got.binormal_z, want.binormal_z);
        if (got.degenerate != want.degenerate)
          report_mismatch("degenerate", got.degenerate, want.degenerate);
      end
    end
  end

  // Watchdog: drop the run when no word moves on either channel for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Extremes, degenerate triangles and a flipped determinant
  task automatic test_directed();
    int one;
    one = 1 << 16;
    send_triangle(mk(0, 0, 0, 0, 0), mk(one, 0, 0, one, 0), mk(0, one, 0, 0, one));
    // negative determinant
    send_triangle(mk(0, 0, 0, 0, 0), mk(one, 0, 0, 0, one), mk(0, one, 0, one, 0));
    // zero determinant: identical texture coordinates
    send_triangle(mk(0, 0, 0, 5, 5), mk(one, 2, 3, 5, 5), mk(7, one, 9, 5, 5));
    // zero tangent: all positions equal
    send_triangle(mk(3, 3, 3, 0, 0), mk(3, 3, 3, one, 0), mk(3, 3, 3, 0, one));
    // zero binormal with nonzero determinant: e2 = 2*e1, du2 = 2*du1
    send_triangle(mk(0, 0, 0, 0, 0), mk(one, 2 * one, 3, one, 0),
                  mk(2 * one, 4 * one, 6, 2 * one, one));
    // field extremes
    send_triangle(mk(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff),
                  mk(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff),
                  mk(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000));
    send_triangle(mk(-1, -1, -1, -1, -1), mk(32'h7fff_ffff, 0, 1, 32'h7fff_ffff, -1),
                  mk(0, 32'h8000_0000, -1, -1, 32'h8000_0000));
    send_triangle(mk(0, 0, 0, 0, 0), mk(1, 0, 0, 1, 0), mk(0, 1, 0, 0, 1));
  endtask

  // Random triangles: mostly full range, some small, some with a degenerate shape
  task automatic test_random();
    tbn_pkg::vtx_t a, b, c;
    int sel;
    for (int t = 0; t < 416; t++) begin
      sel = $urandom_range(0, 9);
      a = rand_vertex(sel >= 6);
      b = rand_vertex(sel >= 6);
      c = rand_vertex(sel >= 6);
      if (sel == 9) begin
        b.tex_u = a.tex_u;
        c.tex_u = a.tex_u;
      end else if (sel == 8) begin
        b.pos_x = a.pos_x; b.pos_y = a.pos_y; b.pos_z = a.pos_z;
        c.pos_x = a.pos_x; c.pos_y = a.pos_y; c.pos_z = a.pos_z;
      end
      send_triangle(a, b, c);
    end
  endtask

  // Hold the sender until every word is out, then resume mid-stream
  task automatic test_drain_pause();
    send_triangle(rand_vertex(0), rand_vertex(0), rand_vertex(0));
    send_vertex(rand_vertex(1));
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    send_vertex(rand_vertex(1));
    send_vertex(rand_vertex(1));
  endtask

  initial begin
    error_count  = 0;
    corners_held = 0;
    corner0      = '0;
    corner1      = '0;
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_drain_pause();
    test_random();

    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (1200) @(posedge clk_i);

    if (error_count == 0 && expected_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/tbn_pkg.sv
design/tbn_in_if.sv
design/tbn_out_if.sv
design/triangle_tangent_binormal_top.sv
design/tbn_checker.sv
dv/tb_top.sv
